>>> rtl/fmr_pkg.sv
package fmr_pkg;

    // Channel count and ramp limit
    localparam int CHANNELS       = 4;
    localparam int CH_W           = $clog2(CHANNELS);
    localparam int MAX_RAMP_STEPS = 64;

    // Field widths
    localparam int CMD_W      = 8;
    localparam int PCT_W      = 7;
    localparam int FRAC_BITS  = 8;
    localparam int POS_W      = CMD_W + FRAC_BITS;
    localparam int PB_W       = 2 * PCT_W;
    localparam int STEP_W     = 7;
    localparam int DUTY_W     = 8;
    localparam int DIV_W      = POS_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    // Configuration reset values
    localparam logic [STEP_W-1:0] STEP_COUNT_RESET = 7'd10;
    localparam logic [PCT_W-1:0]  BALANCE_RESET    = 7'd100;
    localparam logic [PCT_W-1:0]  BALANCE_MAX      = 7'd100;

    // Channels whose direction bit is inverted (b and c)
    localparam logic [CHANNELS-1:0] INVERT_MASK = 4'b0110;

    // Shaping arithmetic: v = pos * power * balance / 10000
    localparam int PROD_W      = POS_W + PB_W + 1;
    localparam int RECIP_W     = 28;
    localparam int RECIP_SHIFT = 41;
    localparam int Q_W         = 15;
    localparam logic [RECIP_W-1:0] RECIP_10K = 28'd219902326;
    // |prod| at or above this saturates to the +-100 percent limit
    localparam logic [PROD_W-1:0]  SAT_PROD  = 31'd256000000;
    localparam logic [Q_W-1:0]     LIMIT_MAG = 15'd25600;
    localparam logic [Q_W-1:0]     MIN_MAG   = 15'd3840;
    localparam logic [Q_W-1:0]     ONE_MAG   = 15'd256;

    // duty = floor(ip * 255 / 100) as one constant multiply and shift
    localparam int IP_W       = Q_W - FRAC_BITS;
    localparam int DRECIP_W   = 23;
    localparam int DUTY_SHIFT = 21;
    localparam logic [DRECIP_W-1:0] DUTY_RECIP = 23'd5347860;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STEP_COUNT,
        REG_BALANCE_A,
        REG_BALANCE_B,
        REG_BALANCE_C,
        REG_BALANCE_D
    } cfg_reg_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_SHAPE_GO,
        ST_SHAPE_WAIT
    } state_t;

    // Input transaction
    typedef struct packed {
        logic                     mode;
        logic signed [CMD_W-1:0]  cmd_a;
        logic signed [CMD_W-1:0]  cmd_b;
        logic signed [CMD_W-1:0]  cmd_c;
        logic signed [CMD_W-1:0]  cmd_d;
        logic [PCT_W-1:0]         power;
    } cmd_t;

    // Output transaction
    typedef struct packed {
        logic              dir_a;
        logic              dir_b;
        logic              dir_c;
        logic              dir_d;
        logic [DUTY_W-1:0] duty_a;
        logic [DUTY_W-1:0] duty_b;
        logic [DUTY_W-1:0] duty_c;
        logic [DUTY_W-1:0] duty_d;
        logic              last;
    } res_t;

    // Sequencer to lane controls
    typedef struct packed {
        logic              load;
        logic              direct;
        logic              div_start;
        logic [STEP_W-1:0] left;
        logic              shape_start;
    } lane_ctl_t;

    // Shaper result of one lane
    typedef struct packed {
        logic              valid;
        logic              neg;
        logic [DUTY_W-1:0] duty;
    } shape_res_t;

    // Lane status back to the sequencer
    typedef struct packed {
        logic       div_done;
        shape_res_t res;
    } lane_stat_t;

endpackage

>>> rtl/fmr_ifs.sv
// Command channel
interface fmr_cmd_if import fmr_pkg::*; ();
    logic valid;
    logic ready;
    cmd_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// Result channel
interface fmr_res_if import fmr_pkg::*; ();
    logic valid;
    logic ready;
    res_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/fmr_div.sv
// Restoring divider, one quotient bit per cycle
module fmr_div import fmr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIV_W-1:0]  dividend,
    input  logic [STEP_W-1:0] divisor,
    output logic              done,
    output logic [DIV_W-1:0]  quotient
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [CNT_W-1:0]  cnt_reg;
    logic              done_reg;
    logic [DIV_W-1:0]  quo_reg;
    logic [STEP_W-1:0] rem_reg;
    logic [STEP_W-1:0] dvs_reg;

    logic [STEP_W:0]   trial;
    logic [STEP_W:0]   trial_sub;
    logic              fits;
    logic [STEP_W-1:0] rem_next;

    // One trial subtraction
    assign trial     = {rem_reg, quo_reg[DIV_W-1]};
    assign trial_sub = trial - {1'b0, dvs_reg};
    assign fits      = trial >= {1'b0, dvs_reg};
    assign rem_next  = fits ? trial_sub[STEP_W-1:0] : trial[STEP_W-1:0];

    // Iteration counter and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == CNT_W'(1));
            if (start)
                cnt_reg <= CNT_W'(DIV_W);
            else if (cnt_reg != '0)
                cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    // Quotient and remainder shift
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> rtl/fmr_shape.sv
// Four-stage shaping pipeline: scale, divide by 10000, clamp, duty
module fmr_shape import fmr_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [POS_W-1:0] pos,
    input  logic [PB_W-1:0]         pb,
    output shape_res_t              res
);

    logic [3:0] vld_reg;

    logic signed [PROD_W-1:0]  prod_next;
    logic signed [PROD_W-1:0]  prod_reg;
    logic [PROD_W-1:0]         mag;
    logic [2*RECIP_W-1:0]      recip_next;
    logic [2*RECIP_W-1:0]      recip_reg;
    logic                      sat_reg;
    logic                      neg2_reg;
    logic [Q_W-1:0]            quo;
    logic [Q_W-1:0]            mag_clamp;
    logic [Q_W-1:0]            mag_final;
    logic [IP_W-1:0]           ip_reg;
    logic                      neg3_reg;
    logic [IP_W+DRECIP_W-1:0]  duty_prod;
    logic [DUTY_W-1:0]         duty_reg;
    logic                      neg4_reg;

    // Stage 1: position times power*balance
    assign prod_next = pos * $signed({1'b0, pb});

    // Stage 2: magnitude times reciprocal of 10000
    assign mag        = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
    assign recip_next = mag[RECIP_W-1:0] * RECIP_10K;

    // Stage 3: clamp and minimum-magnitude rule
    assign quo       = recip_reg[RECIP_SHIFT+Q_W-1:RECIP_SHIFT];
    assign mag_clamp = sat_reg ? LIMIT_MAG : quo;
    always_comb
    begin
        if (mag_clamp <= ONE_MAG)
            mag_final = '0;
        else if (mag_clamp < MIN_MAG)
            mag_final = MIN_MAG;
        else
            mag_final = mag_clamp;
    end

    // Stage 4: integer percent to duty
    assign duty_prod = ip_reg * DUTY_RECIP;

    // Valid pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[2:0], start};
    end

    // Datapath stages
    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        recip_reg <= recip_next;
        sat_reg   <= mag >= SAT_PROD;
        neg2_reg  <= prod_reg[PROD_W-1];
        ip_reg    <= mag_final[Q_W-1:FRAC_BITS];
        neg3_reg  <= neg2_reg && (mag_final != '0);
        duty_reg  <= duty_prod[DUTY_SHIFT+DUTY_W-1:DUTY_SHIFT];
        neg4_reg  <= neg3_reg;
    end

    assign res.valid = vld_reg[3];
    assign res.neg   = neg4_reg;
    assign res.duty  = duty_reg;

endmodule

>>> rtl/fmr_lane.sv
// One motor channel: ramp position, step divider and shaper
module fmr_lane import fmr_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  lane_ctl_t               ctl,
    input  logic signed [CMD_W-1:0] cmd,
    input  logic [PCT_W-1:0]        power,
    input  logic [PCT_W-1:0]        balance,
    output lane_stat_t              stat
);

    logic signed [POS_W-1:0] pos_reg;
    logic signed [POS_W-1:0] target_reg;
    logic [PB_W-1:0]         pb_reg;
    logic                    dneg_reg;

    logic signed [POS_W-1:0] cmd_fix;
    logic signed [POS_W:0]   diff;
    logic [POS_W:0]          dmag;
    logic [DIV_W-1:0]        quo;
    logic signed [POS_W:0]   step;
    logic signed [POS_W:0]   pos_sum;
    logic                    div_done;

    // Command in fixed point
    assign cmd_fix = {cmd, {FRAC_BITS{1'b0}}};

    // Distance to target and signed step
    assign diff    = {target_reg[POS_W-1], target_reg} - {pos_reg[POS_W-1], pos_reg};
    assign dmag    = diff[POS_W] ? (POS_W+1)'(-diff) : (POS_W+1)'(diff);
    assign step    = dneg_reg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    assign pos_sum = {pos_reg[POS_W-1], pos_reg} + step;

    // Ramp position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else if (ctl.load && ctl.direct)
            pos_reg <= cmd_fix;
        else if (div_done)
            pos_reg <= pos_sum[POS_W-1:0];
    end

    // Per-transaction operands
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            target_reg <= cmd_fix;
            pb_reg     <= power * balance;
        end
        if (ctl.div_start)
            dneg_reg <= diff[POS_W];
    end

    fmr_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.div_start),
        .dividend (dmag[DIV_W-1:0]),
        .divisor  (ctl.left),
        .done     (div_done),
        .quotient (quo)
    );

    fmr_shape u_shape
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctl.shape_start),
        .pos   (pos_reg),
        .pb    (pb_reg),
        .res   (stat.res)
    );

    assign stat.div_done = div_done;

endmodule

>>> rtl/four_motor_ramp_pwm_shaper_unit.sv
// Four-channel motor command shaper.
// Commands arrive as transactions on the command channel (valid/ready):
// a mode bit, four signed percent commands and a power percent. Mode 0
// shapes the commands at once and stores them as ramp positions; mode 1
// walks the stored positions toward the commands in step_count steps (at
// most 64) and produces one result transaction per step, the final one
// flagged by last. Each result carries a direction bit and an 8-bit PWM
// duty per channel. The four lanes run in lockstep; each has its own
// divider for the ramp step and a 4-stage shaping pipeline.
// A direct command's result is shaped by the pipeline alone; each ramp
// step is one divider pass followed by the shaping pipeline. A new
// command is accepted once the last result of the previous one is in the
// output register. A ramp with step_count zero produces no result.
// The output register holds a result until the receiver takes it; while it
// is stalled, the next step's division runs but shaping waits.
// Reset clears positions and the sequencer and loads step_count 10 and
// all balances 100. Configuration writes take effect from the next
// command accepted after the write.
module four_motor_ramp_pwm_shaper_unit import fmr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    fmr_cmd_if.sink               command,
    fmr_res_if.source             result,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [STEP_W-1:0] MAX_STEPS = STEP_W'(MAX_RAMP_STEPS);

    state_t state_reg;
    state_t state_next;

    logic [STEP_W-1:0] step_count_reg;
    logic [PCT_W-1:0]  balance_reg [CHANNELS];
    logic [STEP_W-1:0] left_reg;
    logic              out_valid_reg;
    res_t              out_data_reg;

    logic                    accept;
    logic                    out_free;
    logic [STEP_W-1:0]       steps;
    logic [PCT_W-1:0]        bal_in;
    logic [CH_W-1:0]         bal_sel;
    lane_ctl_t               ctl;
    lane_stat_t              lane_stat [CHANNELS];
    logic signed [CMD_W-1:0] cmd_arr [CHANNELS];
    logic [CHANNELS-1:0]     lane_vld;
    logic [CHANNELS-1:0]     lane_dd;
    logic [CHANNELS-1:0]     dir;
    logic                    res_valid;
    logic                    div_done;
    res_t                    merged;

    assign accept   = command.valid && command.ready;
    assign out_free = !out_valid_reg || result.ready;
    assign steps    = (step_count_reg > MAX_STEPS) ? MAX_STEPS : step_count_reg;

    // Configuration registers
    assign bal_in  = (cfg_data > BALANCE_MAX) ? BALANCE_MAX : cfg_data;
    assign bal_sel = CH_W'(cfg_index - CFG_IDX_W'(REG_BALANCE_A));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_count_reg <= STEP_COUNT_RESET;
            for (int i = 0; i < CHANNELS; i++)
                balance_reg[i] <= BALANCE_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_STEP_COUNT: step_count_reg <= cfg_data;
                REG_BALANCE_A,
                REG_BALANCE_B,
                REG_BALANCE_C,
                REG_BALANCE_D:  balance_reg[bal_sel] <= bal_in;
                default: ;
            endcase
        end
    end

    // Lane inputs
    assign cmd_arr[0] = command.payload.cmd_a;
    assign cmd_arr[1] = command.payload.cmd_b;
    assign cmd_arr[2] = command.payload.cmd_c;
    assign cmd_arr[3] = command.payload.cmd_d;

    for (genvar ch = 0; ch < CHANNELS; ch++)
    begin : g_lane
        fmr_lane u_lane
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (ctl),
            .cmd     (cmd_arr[ch]),
            .power   (command.payload.power),
            .balance (balance_reg[ch]),
            .stat    (lane_stat[ch])
        );
        assign lane_vld[ch] = lane_stat[ch].res.valid;
        assign lane_dd[ch]  = lane_stat[ch].div_done;
        assign dir[ch]      = INVERT_MASK[ch] ? lane_stat[ch].res.neg
                                              : !lane_stat[ch].res.neg;
    end

    assign res_valid = lane_vld[0];
    assign div_done  = lane_dd[0];

    // Sequencer state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!command.payload.mode)
                        state_next = ST_SHAPE_GO;
                    else if (steps != '0)
                        state_next = ST_DIV_GO;
                end
            end
            ST_DIV_GO:
                state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
            begin
                if (div_done)
                    state_next = ST_SHAPE_GO;
            end
            ST_SHAPE_GO:
            begin
                if (out_free)
                    state_next = ST_SHAPE_WAIT;
            end
            ST_SHAPE_WAIT:
            begin
                if (res_valid)
                    state_next = (left_reg == STEP_W'(1)) ? ST_IDLE : ST_DIV_GO;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        command.ready   = (state_reg == ST_IDLE);
        ctl.load        = command.valid && (state_reg == ST_IDLE);
        ctl.direct      = !command.payload.mode;
        ctl.div_start   = (state_reg == ST_DIV_GO);
        ctl.left        = left_reg;
        ctl.shape_start = (state_reg == ST_SHAPE_GO) && out_free;
    end

    // Steps remaining, the divisor of the current step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            left_reg <= '0;
        else if (accept)
            left_reg <= command.payload.mode ? steps : STEP_W'(1);
        else if (res_valid)
            left_reg <= left_reg - STEP_W'(1);
    end

    // Merge lane results into one transaction
    always_comb
    begin
        merged.dir_a  = dir[0];
        merged.dir_b  = dir[1];
        merged.dir_c  = dir[2];
        merged.dir_d  = dir[3];
        merged.duty_a = lane_stat[0].res.duty;
        merged.duty_b = lane_stat[1].res.duty;
        merged.duty_c = lane_stat[2].res.duty;
        merged.duty_d = lane_stat[3].res.duty;
        merged.last   = (left_reg == STEP_W'(1));
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_valid)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
            out_data_reg <= merged;
    end

    assign result.valid   = out_valid_reg;
    assign result.payload = out_data_reg;

    // Lanes stay in lockstep
    a_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        (lane_vld == '0 || lane_vld == '1) && (lane_dd == '0 || lane_dd == '1))
        else $error("lanes out of step");

    // A shaped result never lands on an occupied output register
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !out_valid_reg)
        else $error("result overwrote a pending transaction");

    // Divider finishes only while the sequencer waits for it
    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV_WAIT)
        else $error("divider done outside wait state");

    // A busy sequencer always has a nonzero step count
    a_left: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> left_reg != '0)
        else $error("zero steps left while busy");

endmodule

>>> dv/fmr_shape_checker.sv
module fmr_shape_checker import fmr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    fmr_cmd_if                    command,
    fmr_res_if                    result,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Predictor state: register copies and per-channel ramp positions (Q8.8)
    logic [STEP_W-1:0]       steps_cfg;
    logic [PCT_W-1:0]        trim [CHANNELS];
    logic signed [POS_W-1:0] ramp_pos [CHANNELS];

    // Results still owed by the block, oldest first
    res_t due_results [$];
    int   results_seen;

    // Scale one position by power and trim, clamp, apply the minimum-magnitude
    // rule; returns {negative, duty}
    function automatic logic [DUTY_W:0] shape_lane(int ch, logic signed [POS_W-1:0] pos,
                                                   logic [PCT_W-1:0] pwr);
        longint scaled;
        longint mag;
        longint lim;
        longint floor_mag;
        longint one;
        lim       = longint'(LIMIT_MAG);
        floor_mag = longint'(MIN_MAG);
        one       = longint'(ONE_MAG);
        scaled = longint'(pos) * longint'(pwr) * longint'(trim[ch]) / 64'sd10000;
        if (scaled > lim)
            scaled = lim;
        if (scaled < -lim)
            scaled = -lim;
        mag = (scaled < 0) ? -scaled : scaled;
        // small commands above one percent get bumped up to the minimum duty
        if (mag < floor_mag && scaled < -one)
            scaled = -floor_mag;
        else if (mag < floor_mag && scaled > one)
            scaled = floor_mag;
        mag = (scaled < 0) ? -scaled : scaled;
        if (mag <= one)
        begin
            scaled = 0;
            mag    = 0;
        end
        return {scaled < 0, DUTY_W'((mag >>> FRAC_BITS) * 255 / 100)};
    endfunction

    // Build one result transaction from the current positions
    function automatic res_t shaped_result(logic [PCT_W-1:0] pwr, logic is_last);
        res_t                r;
        logic [DUTY_W:0]     lane [CHANNELS];
        logic [CHANNELS-1:0] dirs;
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            lane[ch] = shape_lane(ch, ramp_pos[ch], pwr);
            // channels b and c report reverse polarity
            dirs[ch] = INVERT_MASK[ch] ? lane[ch][DUTY_W] : ~lane[ch][DUTY_W];
        end
        r.dir_a  = dirs[0];
        r.dir_b  = dirs[1];
        r.dir_c  = dirs[2];
        r.dir_d  = dirs[3];
        r.duty_a = lane[0][DUTY_W-1:0];
        r.duty_b = lane[1][DUTY_W-1:0];
        r.duty_c = lane[2][DUTY_W-1:0];
        r.duty_d = lane[3][DUTY_W-1:0];
        r.last   = is_last;
        return r;
    endfunction

    // Update positions for one command and queue every result it causes
    task automatic advance_command(input cmd_t c);
        logic signed [CMD_W-1:0] cmds [CHANNELS];
        int goal [CHANNELS];
        int n_steps;
        int left;
        int i;
        cmds = '{c.cmd_a, c.cmd_b, c.cmd_c, c.cmd_d};
        for (int ch = 0; ch < CHANNELS; ch++)
            goal[ch] = int'(cmds[ch]) * (1 << FRAC_BITS);
        if (!c.mode)
        begin
            for (int ch = 0; ch < CHANNELS; ch++)
                ramp_pos[ch] = POS_W'(goal[ch]);
            due_results.push_back(shaped_result(c.power, 1'b1));
        end
        else
        begin
            n_steps = (steps_cfg > MAX_RAMP_STEPS) ? MAX_RAMP_STEPS : int'(steps_cfg);
            for (i = 0; i < n_steps; i++)
            begin
                left = n_steps - i;
                for (int ch = 0; ch < CHANNELS; ch++)
                    ramp_pos[ch] = POS_W'(int'(ramp_pos[ch])
                                   + (goal[ch] - int'(ramp_pos[ch])) / left);
                due_results.push_back(shaped_result(c.power, i == n_steps - 1));
            end
        end
    endtask

    // Monitor: config writes, accepted commands, accepted results
    always @(posedge clk or negedge rst_n)
    begin : watch
        res_t got;
        res_t want;
        if (!rst_n)
        begin
            steps_cfg = STEP_COUNT_RESET;
            for (int ch = 0; ch < CHANNELS; ch++)
            begin
                trim[ch]     = BALANCE_RESET;
                ramp_pos[ch] = '0;
            end
            due_results.delete();
            results_seen = 0;
            mismatches   = 0;
            pending      = 0;
        end
        else
        begin
            // register write; unused indexes are dropped
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_STEP_COUNT:
                        steps_cfg = cfg_data;
                    REG_BALANCE_A, REG_BALANCE_B, REG_BALANCE_C, REG_BALANCE_D:
                        trim[CH_W'(cfg_index - REG_BALANCE_A)] =
                            (cfg_data > BALANCE_MAX) ? BALANCE_MAX : cfg_data;
                    default: ;
                endcase
            end

            // result transaction against the oldest expectation
            if (result.valid && result.ready)
            begin
                got = result.payload;
                results_seen++;
                if (due_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d arrived with nothing expected: %h",
                                 results_seen, got);
                end
                else
                begin
                    want = due_results.pop_front();
                    if (got.dir_a !== want.dir_a || got.dir_b !== want.dir_b ||
                        got.dir_c !== want.dir_c || got.dir_d !== want.dir_d ||
                        got.duty_a !== want.duty_a || got.duty_b !== want.duty_b ||
                        got.duty_c !== want.duty_c || got.duty_d !== want.duty_d ||
                        got.last !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("res %0d exp dir %b%b%b%b duty %0d %0d %0d %0d last %b",
                                     results_seen,
                                     want.dir_a, want.dir_b, want.dir_c, want.dir_d,
                                     want.duty_a, want.duty_b, want.duty_c, want.duty_d,
                                     want.last);
                            $display("res %0d got dir %b%b%b%b duty %0d %0d %0d %0d last %b",
                                     results_seen,
                                     got.dir_a, got.dir_b, got.dir_c, got.dir_d,
                                     got.duty_a, got.duty_b, got.duty_c, got.duty_d,
                                     got.last);
                        end
                    end
                end
            end

            // command transaction
            if (command.valid && command.ready)
                advance_command(command.payload);

            pending = due_results.size();
        end
    end

endmodule

>>> dv/tb_top.sv
module tb_top import fmr_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    // Indexes past the last register; writes there must do nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = CFG_IDX_W'(REG_BALANCE_D) + 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = '1;

    // Receiver behaviors
    typedef enum int {
        RX_OPEN,
        RX_RANDOM,
        RX_PATTERN
    } rx_style_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    mismatches;
    int                    pending;

    int burst_left;
    bit hold_req;

    fmr_cmd_if command ();
    fmr_res_if result ();

    four_motor_ramp_pwm_shaper_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .command   (command),
        .result    (result),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    fmr_shape_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .command    (command),
        .result     (result),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // 100 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop if the run hangs
    initial
    begin
        #50ms;
        $display("FAILURE");
        $finish;
    end

    // Receiver: shifting stall styles plus a long hold-off on request
    initial
    begin : receiver
        int        style_left;
        int        hold_cnt;
        int        phase;
        rx_style_t style;
        logic [7:0] pattern;
        logic      rdy;
        style_left = 0;
        hold_cnt   = 0;
        phase      = 0;
        style      = RX_OPEN;
        pattern    = 8'hff;
        result.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (style_left == 0)
            begin
                style      = rx_style_t'($urandom_range(0, 2));
                style_left = $urandom_range(32, 256);
                pattern    = 8'($urandom) | 8'h01;
            end
            style_left--;
            phase++;
            if (hold_cnt == 0 && hold_req)
            begin
                hold_cnt = 400;
                hold_req = 1'b0;
            end
            if (hold_cnt != 0)
            begin
                hold_cnt--;
                rdy = 1'b0;
            end
            else
            begin
                case (style)
                    RX_OPEN:   rdy = 1'b1;
                    RX_RANDOM: rdy = 1'($urandom_range(0, 1));
                    default:   rdy = pattern[phase[2:0]];
                endcase
            end
            result.ready <= rdy;
        end
    end

    function automatic cmd_t make_cmd(logic mode, int a, int b, int c, int d, int pwr);
        cmd_t m;
        m.mode  = mode;
        m.cmd_a = CMD_W'(a);
        m.cmd_b = CMD_W'(b);
        m.cmd_c = CMD_W'(c);
        m.cmd_d = CMD_W'(d);
        m.power = PCT_W'(pwr);
        return m;
    endfunction

    // Mostly legal percents, with the minimum-duty band, the rails and raw bytes
    function automatic int random_pct();
        int v;
        case ($urandom_range(0, 7))
            0:       v = int'($urandom_range(0, 255)) - 128;
            1:       v = int'($urandom_range(0, 32)) - 16;
            2:       v = $urandom_range(0, 1) ? 100 : -100;
            default: v = int'($urandom_range(0, 200)) - 100;
        endcase
        return v;
    endfunction

    function automatic cmd_t random_cmd(bit direct_only);
        return make_cmd(direct_only ? 1'b0 : ($urandom_range(0, 4) < 3),
                        random_pct(), random_pct(), random_pct(), random_pct(),
                        ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127)
                                                     : $urandom_range(0, 100));
    endfunction

    // Offer one command; bursts of back-to-back transactions with random gaps
    task automatic send_cmd(input cmd_t c);
        int gap;
        if (burst_left <= 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 3);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            if (gap != 0)
            begin
                command.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        command.valid   <= 1'b1;
        command.payload <= c;
        do
            @(posedge clk);
        while (!command.ready);
    endtask

    // Stop offering and wait for the block to drain, including zero-step ramps
    task automatic settle();
        command.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // Reprogram every register while idle, plus one write to an unused index
    task automatic program_regs(input int steps, input int bal_a, input int bal_b,
                                input int bal_c, input int bal_d);
        settle();
        write_reg(REG_STEP_COUNT, CFG_DATA_W'(steps));
        write_reg(REG_BALANCE_A, CFG_DATA_W'(bal_a));
        write_reg(REG_SPARE_FIRST + CFG_IDX_W'($urandom_range(0, REG_SPARE_LAST
                                                              - REG_SPARE_FIRST)),
                  CFG_DATA_W'($urandom));
        write_reg(REG_BALANCE_B, CFG_DATA_W'(bal_b));
        write_reg(REG_BALANCE_C, CFG_DATA_W'(bal_c));
        write_reg(REG_BALANCE_D, CFG_DATA_W'(bal_d));
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    function automatic int random_steps();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return $urandom_range(65, 127);
            2:       return MAX_RAMP_STEPS;
            default: return $urandom_range(1, 6);
        endcase
    endfunction

    function automatic int random_trim();
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return $urandom_range(101, 127);
            2, 3:    return 100;
            default: return $urandom_range(1, 100);
        endcase
    endfunction

    // Stimulus
    initial
    begin : stimulus
        rst_n           <= 1'b0;
        cfg_wr_en       <= 1'b0;
        cfg_index       <= '0;
        cfg_data        <= '0;
        command.valid   <= 1'b0;
        command.payload <= '0;
        burst_left = 0;
        hold_req   = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // rails, zero, out-of-range inputs and the minimum-duty band
        send_cmd(make_cmd(1'b0, 100, -100, 100, -100, 100));
        send_cmd(make_cmd(1'b0, -100, 100, -100, 100, 100));
        send_cmd(make_cmd(1'b0, 0, 0, 0, 0, 100));
        send_cmd(make_cmd(1'b0, 127, -128, 127, -128, 127));
        send_cmd(make_cmd(1'b0, 1, -1, 2, -2, 100));
        send_cmd(make_cmd(1'b0, 14, -14, 15, -15, 100));
        send_cmd(make_cmd(1'b0, 100, 100, 100, 100, 0));
        send_cmd(make_cmd(1'b0, 100, -100, 100, -100, 1));
        // ramps with the reset step count
        send_cmd(make_cmd(1'b1, 100, -100, 50, -50, 100));
        send_cmd(make_cmd(1'b1, -100, 100, 0, 7, 60));

        // zero steps: the ramp emits nothing and keeps the positions
        program_regs(0, 0, 127, 50, 1);
        send_cmd(make_cmd(1'b1, 80, 80, 80, 80, 100));
        send_cmd(make_cmd(1'b0, 90, -90, 90, -90, 100));

        // step count beyond the limit runs the longest ramp
        program_regs(127, 100, 100, 100, 100);
        send_cmd(make_cmd(1'b1, -128, 127, 3, -3, 127));

        program_regs(1, 100, 99, 100, 37);
        send_cmd(make_cmd(1'b1, 60, -60, 60, -60, 85));
        send_cmd(make_cmd(1'b0, -7, 7, -7, 7, 100));
        send_cmd(make_cmd(1'b1, 0, 0, 0, 0, 100));

        // random phases, each with its own register setting
        for (int p = 0; p < 12; p++)
        begin
            program_regs(random_steps(), random_trim(), random_trim(),
                         random_trim(), random_trim());
            for (int n = 0; n < 27; n++)
                send_cmd(random_cmd(1'b0));

            // long receiver hold-off while direct commands keep coming
            if (p == 5)
            begin
                settle();
                hold_req = 1'b1;
                for (int n = 0; n < 20; n++)
                    send_cmd(random_cmd(1'b1));
            end
        end

        settle();
        if (mismatches == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
